// File: sv/udp_receive_checksum_check_top_assert.svh
// Assertion macros for the UDP receive checksum checker.
`ifndef UDP_RECEIVE_CHECKSUM_CHECK_TOP_ASSERT_SVH
`define UDP_RECEIVE_CHECKSUM_CHECK_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define UDPC_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("udpc: implication check failed");
`define UDPC_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("udpc: next-cycle check failed");
`else
`define UDPC_ASSERT_IMP(lbl, pre, post)
`define UDPC_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: sv/udpc_pkg.sv
// Shared types, constants and checksum helpers for the UDP receive checker.
`timescale 1ns / 1ps
package udpc_pkg;

   localparam logic [15:0] UDP_PROTO = 16'd17;
   localparam logic [15:0] HDR_BYTES = 16'd8;
   localparam logic [15:0] WORD_MAX  = 16'hFFFF;

   localparam logic [15:0] DHCP_PORT_RESET = 16'd68;
   localparam logic [15:0] DNS_PORT_RESET  = 16'd53;

   localparam logic [7:0] CSR_DHCP_PORT = 8'd0;
   localparam logic [7:0] CSR_DNS_PORT  = 8'd1;

   localparam logic [2:0] ST_OK_DHCP   = 3'd0;
   localparam logic [2:0] ST_OK_DNS    = 3'd1;
   localparam logic [2:0] ST_OK_OTHER  = 3'd2;
   localparam logic [2:0] ST_BAD_LEN   = 3'd3;
   localparam logic [2:0] ST_BAD_CKSUM = 3'd4;

   // One byte request after the address seed is formed
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] seed;
   } udpc_byte_type;

   // Datagram state captured on the last byte
   typedef struct packed {
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] length;
      logic [15:0] checksum;
      logic [15:0] sum;
      logic [7:0]  hold;
      logic [15:0] position;
   } udpc_snap_type;

   // Fold a wide sum down to a 16-bit ones' complement value
   function automatic logic [15:0] oc_fold(input logic [18:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
      return f2[15:0];
   endfunction

   // Place a byte into the high or low half of a header word
   function automatic logic [15:0] put_byte(input logic [15:0] w, input logic odd,
                                            input logic [7:0] b);
      return odd ? {w[15:8], b} : {b, w[7:0]};
   endfunction

endpackage

// File: sv/udp_receive_checksum_check_top.sv
// Top level of the UDP receive checksum checker.
`timescale 1ns / 1ps
// Takes one UDP datagram byte per request, in wire order, and accepts a new
// byte every cycle while req_stall is low. The request passes an input
// register, a seed stage that sums the IPv4 addresses and protocol, and the
// per-byte accumulator, whose add with end-around carry feeds the running
// sum back. A byte marked last yields one result, through the snapshot slot
// and the output register; other bytes yield none. A stalled result in the
// output register, plus one more verdict in the snapshot slot, do not block
// later bytes. The next last byte then waits in the seed stage, and requests
// stall once the input register behind it is full.
// Configuration writes are always taken (csr_ready is tied high).
`include "udp_receive_checksum_check_top_assert.svh"
module udp_receive_checksum_check_top import udpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [15:0] rsp_payload_length,
   output logic [15:0] rsp_computed_sum,
   output logic        rsp_sum_skipped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic          v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic          v1_in, v2_in, v3_in, rsp_valid_in;
   logic [15:0]   dhcp_port_ff, dns_port_ff;
   logic          go1, go2, go3, free2, free3, accept;
   udpc_byte_type item;
   udpc_snap_type snap;

   // Stage advance chain from the result side back to the request side
   always_comb begin
      go3      = v3_ff && (!rsp_valid_ff || !rsp_stall);
      free3    = !v3_ff || go3;
      go2      = v2_ff && (!item.last_byte || free3);
      free2    = !v2_ff || go2;
      go1      = v1_ff && free2;
      accept   = req_valid && !req_stall;
      v1_in    = accept || (v1_ff && !go1);
      v2_in    = go1 || (v2_ff && !go2);
      v3_in    = (go2 && item.last_byte) || (v3_ff && !go3);
      rsp_valid_in = go3 || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = v1_ff && !go1;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Write configuration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         dhcp_port_ff <= DHCP_PORT_RESET;
         dns_port_ff  <= DNS_PORT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DHCP_PORT) begin
            dhcp_port_ff <= csr_wdata;
         end
         if (csr_index == CSR_DNS_PORT) begin
            dns_port_ff <= csr_wdata;
         end
      end
   end

   udpc_front u_front (
      .clock      (clock),
      .load_in    (accept),
      .load_seed  (go1),
      .rx_byte    (req_rx_byte),
      .first_byte (req_first_byte),
      .last_byte  (req_last_byte),
      .source_ip  (req_source_ip),
      .dest_ip    (req_dest_ip),
      .item       (item)
   );

   udpc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (go2),
      .load_snap (go2 && item.last_byte),
      .item      (item),
      .snap      (snap)
   );

   udpc_verdict u_verdict (
      .clock            (clock),
      .load             (go3),
      .snap             (snap),
      .dhcp_client_port (dhcp_port_ff),
      .dns_port         (dns_port_ff),
      .status           (rsp_status),
      .source_port      (rsp_source_port),
      .dest_port        (rsp_dest_port),
      .payload_length   (rsp_payload_length),
      .computed_sum     (rsp_computed_sum),
      .sum_skipped      (rsp_sum_skipped)
   );

   // A last byte leaves the accumulator only into a free snapshot slot
   `UDPC_ASSERT_IMP(a_snap_slot_free, go2 && item.last_byte, free3)
   // A verdict moved out always shows as a result next cycle
   `UDPC_ASSERT_NXT(a_verdict_shown, go3, rsp_valid_ff)
   // A taken result with nothing behind it empties the output
   `UDPC_ASSERT_NXT(a_rsp_drains, rsp_valid_ff && !rsp_stall && !go3, !rsp_valid_ff)

endmodule

// File: sv/udpc_front.sv
// Input register and pseudo header address seed stage.
`timescale 1ns / 1ps
module udpc_front import udpc_pkg::*; (
   input  logic          clock,
   input  logic          load_in,
   input  logic          load_seed,
   input  logic [7:0]    rx_byte,
   input  logic          first_byte,
   input  logic          last_byte,
   input  logic [31:0]   source_ip,
   input  logic [31:0]   dest_ip,
   output udpc_byte_type item
);

   logic [7:0]    byte_ff;
   logic          first_ff;
   logic          last_ff;
   logic [31:0]   sip_ff;
   logic [31:0]   dip_ff;
   udpc_byte_type item_ff;
   udpc_byte_type item_in;
   logic [18:0]   seed_sum;

   // Hold the raw request
   always_ff @(posedge clock) begin
      if (load_in) begin
         byte_ff  <= rx_byte;
         first_ff <= first_byte;
         last_ff  <= last_byte;
         sip_ff   <= source_ip;
         dip_ff   <= dest_ip;
      end
   end

   // Sum the address words and the protocol number
   always_comb begin
      seed_sum = {3'd0, sip_ff[31:16]} + {3'd0, sip_ff[15:0]}
               + {3'd0, dip_ff[31:16]} + {3'd0, dip_ff[15:0]}
               + {3'd0, UDP_PROTO};
      item_in.rx_byte    = byte_ff;
      item_in.first_byte = first_ff;
      item_in.last_byte  = last_ff;
      item_in.seed       = oc_fold(seed_sum);
   end

   always_ff @(posedge clock) begin
      if (load_seed) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// File: sv/udpc_accum.sv
// Per-byte header capture and running checksum accumulator.
`timescale 1ns / 1ps
module udpc_accum import udpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          load_snap,
   input  udpc_byte_type item,
   output udpc_snap_type snap
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] cks_ff, cks_in;
   udpc_snap_type snap_ff, snap_in;

   logic [15:0] p;
   logic [15:0] sum_base;
   logic [7:0]  hold_base;
   logic [15:0] word;
   logic        summed;
   logic [18:0] sum_raw;

   always_comb begin
      // Restart the datagram on a first mark
      p         = item.first_byte ? 16'd0 : byte_count_ff;
      sum_base  = item.first_byte ? item.seed : sum_ff;
      hold_base = item.first_byte ? 8'd0 : hold_ff;
      src_in    = item.first_byte ? 16'd0 : src_ff;
      dst_in    = item.first_byte ? 16'd0 : dst_ff;
      len_in    = item.first_byte ? 16'd0 : len_ff;
      cks_in    = item.first_byte ? 16'd0 : cks_ff;

      // Capture header fields
      if (p < 16'd2) begin
         src_in = put_byte(src_in, p[0], item.rx_byte);
      end else if (p < 16'd4) begin
         dst_in = put_byte(dst_in, p[0], item.rx_byte);
      end else if (p < 16'd6) begin
         len_in = put_byte(len_in, p[0], item.rx_byte);
      end else if (p < HDR_BYTES) begin
         cks_in = put_byte(cks_in, p[0], item.rx_byte);
      end

      // Pair bytes into words and add; the length word counts twice
      summed  = (p < 16'd6) || ((p >= HDR_BYTES) && (p < len_in));
      word    = {hold_base, item.rx_byte};
      hold_in = hold_base;
      sum_in  = sum_base;
      sum_raw = '0;
      if (summed) begin
         if (!p[0]) begin
            hold_in = item.rx_byte;
         end else begin
            sum_raw = {3'd0, sum_base} + {3'd0, word}
                    + ((p == 16'd5) ? {3'd0, word} : 19'd0);
            sum_in  = oc_fold(sum_raw);
         end
      end

      // Saturate the byte count
      byte_count_in = (p < WORD_MAX) ? p + 16'd1 : WORD_MAX;

      snap_in.src_port = src_in;
      snap_in.dst_port = dst_in;
      snap_in.length   = len_in;
      snap_in.checksum = cks_in;
      snap_in.sum      = sum_in;
      snap_in.hold     = hold_in;
      snap_in.position = p;
   end

   // Advance datagram state one byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sum_ff        <= '0;
         hold_ff       <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         len_ff        <= '0;
         cks_ff        <= '0;
      end else if (advance) begin
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         hold_ff       <= hold_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         len_ff        <= len_in;
         cks_ff        <= cks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_snap) begin
         snap_ff <= snap_in;
      end
   end

   assign snap = snap_ff;

endmodule

// File: sv/udpc_verdict.sv
// Length check, checksum compare and port classification into the result register.
`timescale 1ns / 1ps
module udpc_verdict import udpc_pkg::*; (
   input  logic          clock,
   input  logic          load,
   input  udpc_snap_type snap,
   input  logic [15:0]   dhcp_client_port,
   input  logic [15:0]   dns_port,
   output logic [2:0]    status,
   output logic [15:0]   source_port,
   output logic [15:0]   dest_port,
   output logic [15:0]   payload_length,
   output logic [15:0]   computed_sum,
   output logic          sum_skipped
);

   logic [2:0]  status_ff, status_in;
   logic [15:0] src_ff;
   logic [15:0] dst_ff;
   logic [15:0] payload_ff, payload_in;
   logic [15:0] computed_ff, computed_in;
   logic        skipped_ff, skipped_in;

   logic [16:0] arrived;
   logic        bad_len;
   logic [15:0] padded;
   logic [15:0] cks_calc;
   logic        skip;

   always_comb begin
      arrived  = {1'b0, snap.position} + 17'd1;
      bad_len  = (snap.length < HDR_BYTES) || ({1'b0, snap.length} > arrived);
      // Pad an odd trailing byte with a zero low byte
      padded   = snap.length[0] ?
                 oc_fold({3'd0, snap.sum} + {3'd0, snap.hold, 8'd0}) : snap.sum;
      cks_calc = ~padded;
      skip     = (snap.checksum == 16'd0) || (snap.checksum == WORD_MAX);

      status_in   = ST_OK_OTHER;
      payload_in  = snap.length - HDR_BYTES;
      computed_in = cks_calc;
      skipped_in  = skip;
      priority if (bad_len) begin
         status_in   = ST_BAD_LEN;
         payload_in  = '0;
         computed_in = '0;
         skipped_in  = 1'b0;
      end else if (!skip && (snap.checksum != cks_calc)) begin
         status_in = ST_BAD_CKSUM;
      end else if (snap.dst_port == dhcp_client_port) begin
         status_in = ST_OK_DHCP;
      end else if (snap.src_port == dns_port) begin
         status_in = ST_OK_DNS;
      end else begin
         status_in = ST_OK_OTHER;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= status_in;
         src_ff      <= snap.src_port;
         dst_ff      <= snap.dst_port;
         payload_ff  <= payload_in;
         computed_ff <= computed_in;
         skipped_ff  <= skipped_in;
      end
   end

   assign status         = status_ff;
   assign source_port    = src_ff;
   assign dest_port      = dst_ff;
   assign payload_length = payload_ff;
   assign computed_sum   = computed_ff;
   assign sum_skipped    = skipped_ff;

endmodule
